// ===== hw/rtl/msd_pkg.sv =====
package msd_pkg;

  // Primary opcodes (instruction bits 31:26)
  localparam logic [5:0] OPC_RFMT  = 6'h00;
  localparam logic [5:0] OPC_J     = 6'h02;
  localparam logic [5:0] OPC_BEQ   = 6'h04;
  localparam logic [5:0] OPC_BNE   = 6'h05;
  localparam logic [5:0] OPC_ADDIU = 6'h09;
  localparam logic [5:0] OPC_ANDI  = 6'h0C;
  localparam logic [5:0] OPC_ORI   = 6'h0D;
  localparam logic [5:0] OPC_LHU   = 6'h25;
  localparam logic [5:0] OPC_SH    = 6'h29;

  // R-format function codes (instruction bits 5:0)
  localparam logic [5:0] FN_NOP    = 6'h00;
  localparam logic [5:0] FN_BREAK  = 6'h0D;
  localparam logic [5:0] FN_ADDU   = 6'h21;
  localparam logic [5:0] FN_AND    = 6'h24;
  localparam logic [5:0] FN_OR     = 6'h25;

  // ALU operation codes
  localparam logic [1:0] ALU_NONE  = 2'd0;
  localparam logic [1:0] ALU_ADD   = 2'd1;
  localparam logic [1:0] ALU_AND   = 2'd2;
  localparam logic [1:0] ALU_OR    = 2'd3;

  // Memory access kinds and sizes
  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_READU = 2'd1;
  localparam logic [1:0] MEM_WRITE = 2'd2;
  localparam logic [1:0] MEM_HALF  = 2'd2;
  localparam logic [1:0] MEM_NOSZ  = 2'd0;

  // Exception codes
  localparam logic [1:0] EXC_NONE  = 2'd0;
  localparam logic [1:0] EXC_BREAK = 2'd1;
  localparam logic [1:0] EXC_RI    = 2'd2;

  // Jump keeps the top nibble of the delay-slot address
  localparam logic [31:0] JUMP_REGION_MASK = 32'hF000_0000;

  // Decoded result of one instruction
  typedef struct packed {
    logic [1:0]  alu_function;
    logic        alu_b_immediate;
    logic [31:0] immediate;
    logic [4:0]  dest_reg;
    logic [1:0]  mem_access;
    logic [1:0]  mem_bytes;
    logic        branch_eval;
    logic        branch_taken;
    logic [31:0] branch_target;
    logic [1:0]  exception_code;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
  } dec_result_t;

endpackage

// ===== hw/rtl/mips_subset_decode_stage.sv =====
// MIPS subset decode stage.
// Input channel: an instruction transaction (word, address, register file
// values and forwarded values) is taken at a rising edge where start is
// high and busy is low. busy is always low: one transaction may be taken
// in every cycle, back to back.
// Result channel: out_valid is high for exactly one cycle with the decoded
// fields on the out_ ports; that cycle's closing edge takes the result.
// Path: the transaction is captured in an input register, decoded by a
// single level of combinational logic and captured in the result register,
// which drives out_valid and the out_ ports.
// Throughput: one instruction per cycle, set by the two register stages.
// The widest path is the 32-bit branch operand compare and target adder.
// Reset (rst_n low, synchronous) clears both valid flags, so no result is
// strobed for transactions in flight; payload registers are not reset.
// The receiver cannot stall: every result is presented once and lost if
// not taken in that cycle.
module mips_subset_decode_stage import msd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_instruction,
  input  logic [31:0] in_instr_address,
  input  logic [31:0] in_rs_value,
  input  logic [31:0] in_rt_value,
  input  logic        in_fwd_rs_hit,
  input  logic [31:0] in_fwd_rs_value,
  input  logic        in_fwd_rt_hit,
  input  logic [31:0] in_fwd_rt_value,
  output logic        out_valid,
  output logic [1:0]  out_alu_function,
  output logic        out_alu_b_immediate,
  output logic [31:0] out_immediate,
  output logic [4:0]  out_dest_reg,
  output logic [1:0]  out_mem_access,
  output logic [1:0]  out_mem_bytes,
  output logic        out_branch_eval,
  output logic        out_branch_taken,
  output logic [31:0] out_branch_target,
  output logic [1:0]  out_exception_code,
  output logic [31:0] out_operand_a,
  output logic [31:0] out_operand_b
);

  logic        in_valid_r;
  logic [31:0] instr_r;
  logic [31:0] addr_r;
  logic [31:0] rs_val_r;
  logic [31:0] rt_val_r;
  logic        fwd_rs_hit_r;
  logic [31:0] fwd_rs_val_r;
  logic        fwd_rt_hit_r;
  logic [31:0] fwd_rt_val_r;

  logic        out_valid_r;
  dec_result_t res_r;
  dec_result_t res_nxt;

  logic        accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= accept;
    end
    if (accept) begin
      instr_r      <= in_instruction;
      addr_r       <= in_instr_address;
      rs_val_r     <= in_rs_value;
      rt_val_r     <= in_rt_value;
      fwd_rs_hit_r <= in_fwd_rs_hit;
      fwd_rs_val_r <= in_fwd_rs_value;
      fwd_rt_hit_r <= in_fwd_rt_hit;
      fwd_rt_val_r <= in_fwd_rt_value;
    end
  end

  // Instruction fields
  logic [5:0]  opc;
  logic [4:0]  rs;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [5:0]  fn;
  logic [15:0] imm16;
  logic [31:0] simm;
  logic [31:0] zimm;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [31:0] cmp_a;
  logic [31:0] cmp_b;
  logic        ops_equal;
  logic [31:0] pc_plus4;

  assign opc   = instr_r[31:26];
  assign rs    = instr_r[25:21];
  assign rt    = instr_r[20:16];
  assign rd    = instr_r[15:11];
  assign fn    = instr_r[5:0];
  assign imm16 = instr_r[15:0];
  assign simm  = {{16{imm16[15]}}, imm16};
  assign zimm  = {16'h0000, imm16};

  // Register zero reads as zero and never takes a forwarded value
  assign op_a  = (rs != 5'd0) ? rs_val_r : 32'h0;
  assign op_b  = (rt != 5'd0) ? rt_val_r : 32'h0;
  assign cmp_a = ((rs != 5'd0) && fwd_rs_hit_r) ? fwd_rs_val_r : op_a;
  assign cmp_b = ((rt != 5'd0) && fwd_rt_hit_r) ? fwd_rt_val_r : op_b;
  assign ops_equal = (cmp_a == cmp_b);
  assign pc_plus4  = addr_r + 32'd4;

  // Decode
  always_comb begin
    res_nxt = '0;
    res_nxt.operand_a = op_a;
    res_nxt.operand_b = op_b;
    case (opc)
      OPC_RFMT: begin
        res_nxt.dest_reg = rd;
        case (fn)
          FN_NOP:   res_nxt.dest_reg = 5'd0;
          FN_ADDU:  res_nxt.alu_function = ALU_ADD;
          FN_AND:   res_nxt.alu_function = ALU_AND;
          FN_OR:    res_nxt.alu_function = ALU_OR;
          FN_BREAK: res_nxt.exception_code = EXC_BREAK;
          default:  res_nxt.exception_code = EXC_RI;
        endcase
      end
      OPC_J: begin
        res_nxt.branch_taken  = 1'b1;
        res_nxt.branch_target = (pc_plus4 & JUMP_REGION_MASK) |
                                {4'h0, instr_r[25:0], 2'b00};
      end
      default: begin
        // I-format: immediate as ALU B, rt as destination
        res_nxt.alu_b_immediate = 1'b1;
        res_nxt.immediate       = simm;
        res_nxt.dest_reg        = rt;
        case (opc)
          OPC_ADDIU: res_nxt.alu_function = ALU_ADD;
          OPC_ANDI: begin
            res_nxt.alu_function = ALU_AND;
            res_nxt.immediate    = zimm;
          end
          OPC_ORI: begin
            res_nxt.alu_function = ALU_OR;
            res_nxt.immediate    = zimm;
          end
          OPC_LHU: begin
            res_nxt.alu_function = ALU_ADD;
            res_nxt.mem_access   = MEM_READU;
            res_nxt.mem_bytes    = MEM_HALF;
          end
          OPC_SH: begin
            res_nxt.alu_function = ALU_ADD;
            res_nxt.mem_access   = MEM_WRITE;
            res_nxt.mem_bytes    = MEM_HALF;
            res_nxt.dest_reg     = 5'd0;
          end
          OPC_BEQ, OPC_BNE: begin
            res_nxt.dest_reg      = 5'd0;
            res_nxt.branch_eval   = 1'b1;
            res_nxt.branch_taken  = (opc == OPC_BEQ) ? ops_equal : !ops_equal;
            res_nxt.branch_target = pc_plus4 + {simm[29:0], 2'b00};
          end
          default: res_nxt.exception_code = EXC_RI;
        endcase
      end
    endcase
    // An exception cancels ALU, memory and writeback
    if (res_nxt.exception_code != EXC_NONE) begin
      res_nxt.alu_function = ALU_NONE;
      res_nxt.mem_access   = MEM_NONE;
      res_nxt.dest_reg     = 5'd0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
    if (in_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_alu_function    = res_r.alu_function;
  assign out_alu_b_immediate = res_r.alu_b_immediate;
  assign out_immediate       = res_r.immediate;
  assign out_dest_reg        = res_r.dest_reg;
  assign out_mem_access      = res_r.mem_access;
  assign out_mem_bytes       = res_r.mem_bytes;
  assign out_branch_eval     = res_r.branch_eval;
  assign out_branch_taken    = res_r.branch_taken;
  assign out_branch_target   = res_r.branch_target;
  assign out_exception_code  = res_r.exception_code;
  assign out_operand_a       = res_r.operand_a;
  assign out_operand_b       = res_r.operand_b;

endmodule

// ===== tb/sv/mips_subset_decode_stage_test.sv =====
module mips_subset_decode_stage_test import msd_pkg::*;;

  // Encodings outside the supported subset
  localparam logic [5:0] OPC_REGIMM  = 6'h01;
  localparam logic [5:0] OPC_TOP     = 6'h3F;
  localparam logic [5:0] FN_TOP      = 6'h3F;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_ITEMS  = 1400;
  localparam int DRAIN_CYCLES  = 4;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_instruction = '0;
  logic [31:0] in_instr_address = '0;
  logic [31:0] in_rs_value = '0;
  logic [31:0] in_rt_value = '0;
  logic        in_fwd_rs_hit = 1'b0;
  logic [31:0] in_fwd_rs_value = '0;
  logic        in_fwd_rt_hit = 1'b0;
  logic [31:0] in_fwd_rt_value = '0;
  logic        out_valid;
  logic [1:0]  out_alu_function;
  logic        out_alu_b_immediate;
  logic [31:0] out_immediate;
  logic [4:0]  out_dest_reg;
  logic [1:0]  out_mem_access;
  logic [1:0]  out_mem_bytes;
  logic        out_branch_eval;
  logic        out_branch_taken;
  logic [31:0] out_branch_target;
  logic [1:0]  out_exception_code;
  logic [31:0] out_operand_a;
  logic [31:0] out_operand_b;

  dec_result_t pending_decodes[$];
  dec_result_t head_decode;
  int          fail_count = 0;
  int          cycle_count = 0;
  bit          no_gaps = 1'b0;

  mips_subset_decode_stage dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_instruction      (in_instruction),
    .in_instr_address    (in_instr_address),
    .in_rs_value         (in_rs_value),
    .in_rt_value         (in_rt_value),
    .in_fwd_rs_hit       (in_fwd_rs_hit),
    .in_fwd_rs_value     (in_fwd_rs_value),
    .in_fwd_rt_hit       (in_fwd_rt_hit),
    .in_fwd_rt_value     (in_fwd_rt_value),
    .out_valid           (out_valid),
    .out_alu_function    (out_alu_function),
    .out_alu_b_immediate (out_alu_b_immediate),
    .out_immediate       (out_immediate),
    .out_dest_reg        (out_dest_reg),
    .out_mem_access      (out_mem_access),
    .out_mem_bytes       (out_mem_bytes),
    .out_branch_eval     (out_branch_eval),
    .out_branch_taken    (out_branch_taken),
    .out_branch_target   (out_branch_target),
    .out_exception_code  (out_exception_code),
    .out_operand_a       (out_operand_a),
    .out_operand_b       (out_operand_b)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Expected decode of one instruction, forwarding applied to the branch compare only
  function automatic dec_result_t predict_decode(logic [31:0] word, logic [31:0] pc,
                                                 logic [31:0] rs_val, logic [31:0] rt_val,
                                                 logic rs_hit, logic [31:0] rs_fwd,
                                                 logic rt_hit, logic [31:0] rt_fwd);
    dec_result_t r;
    logic [5:0]  opc;
    logic [5:0]  fn;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [15:0] imm16;
    logic [31:0] simm;
    logic [31:0] pc_next;
    logic [31:0] cmp_a;
    logic [31:0] cmp_b;
    opc   = word[31:26];
    rs    = word[25:21];
    rt    = word[20:16];
    rd    = word[15:11];
    fn    = word[5:0];
    imm16 = word[15:0];
    simm  = {{16{imm16[15]}}, imm16};
    pc_next = pc + 32'd4;
    r = '0;
    r.operand_a = (rs != 5'd0) ? rs_val : 32'd0;
    r.operand_b = (rt != 5'd0) ? rt_val : 32'd0;
    if (opc == OPC_RFMT) begin
      r.dest_reg = rd;
      case (fn)
        FN_NOP:   r.dest_reg = 5'd0;
        FN_ADDU:  r.alu_function = ALU_ADD;
        FN_AND:   r.alu_function = ALU_AND;
        FN_OR:    r.alu_function = ALU_OR;
        FN_BREAK: r.exception_code = EXC_BREAK;
        default:  r.exception_code = EXC_RI;
      endcase
    end else if (opc == OPC_J) begin
      r.branch_taken  = 1'b1;
      r.branch_target = (pc_next & JUMP_REGION_MASK) | {4'b0, word[25:0], 2'b00};
    end else begin
      r.alu_b_immediate = 1'b1;
      r.immediate       = simm;
      r.dest_reg        = rt;
      case (opc)
        OPC_ADDIU: r.alu_function = ALU_ADD;
        OPC_ANDI: begin
          r.alu_function = ALU_AND;
          r.immediate    = {16'h0000, imm16};
        end
        OPC_ORI: begin
          r.alu_function = ALU_OR;
          r.immediate    = {16'h0000, imm16};
        end
        OPC_LHU: begin
          r.alu_function = ALU_ADD;
          r.mem_access   = MEM_READU;
          r.mem_bytes    = MEM_HALF;
        end
        OPC_SH: begin
          r.alu_function = ALU_ADD;
          r.mem_access   = MEM_WRITE;
          r.mem_bytes    = MEM_HALF;
          r.dest_reg     = 5'd0;
        end
        OPC_BEQ, OPC_BNE: begin
          // register 0 never takes a forwarded value
          cmp_a = (rs != 5'd0 && rs_hit) ? rs_fwd : r.operand_a;
          cmp_b = (rt != 5'd0 && rt_hit) ? rt_fwd : r.operand_b;
          r.dest_reg      = 5'd0;
          r.branch_eval   = 1'b1;
          r.branch_taken  = (opc == OPC_BEQ) ? (cmp_a == cmp_b) : (cmp_a != cmp_b);
          r.branch_target = pc_next + {simm[29:0], 2'b00};
        end
        default: r.exception_code = EXC_RI;
      endcase
    end
    // an exception cancels ALU, memory and writeback
    if (r.exception_code != EXC_NONE) begin
      r.alu_function = ALU_NONE;
      r.mem_access   = MEM_NONE;
      r.dest_reg     = 5'd0;
    end
    return r;
  endfunction

  function automatic logic [31:0] r_word(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                         logic [5:0] fn);
    return {OPC_RFMT, rs, rt, rd, 5'd0, fn};
  endfunction

  function automatic logic [31:0] i_word(logic [5:0] opc, logic [4:0] rs, logic [4:0] rt,
                                         logic [15:0] imm);
    return {opc, rs, rt, imm};
  endfunction

  // mostly short gaps, the odd long one
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // start held low for a number of edges, with noise on the payload
  task automatic idle_gap(int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      start          <= 1'b0;
      in_instruction <= $urandom;
      in_rs_value    <= $urandom;
      in_fwd_rs_hit  <= 1'($urandom_range(0, 1));
      repeat (cycles) @(posedge clk);
    end
  endtask

  // one instruction transaction, then a gap
  task automatic send_decode(logic [31:0] word, logic [31:0] pc,
                             logic [31:0] rs_val, logic [31:0] rt_val,
                             logic rs_hit, logic [31:0] rs_fwd,
                             logic rt_hit, logic [31:0] rt_fwd);
    @(negedge clk);
    start            <= 1'b1;
    in_instruction   <= word;
    in_instr_address <= pc;
    in_rs_value      <= rs_val;
    in_rt_value      <= rt_val;
    in_fwd_rs_hit    <= rs_hit;
    in_fwd_rs_value  <= rs_fwd;
    in_fwd_rt_hit    <= rt_hit;
    in_fwd_rt_value  <= rt_fwd;
    do @(posedge clk); while (busy !== 1'b0);
    pending_decodes.push_back(predict_decode(word, pc, rs_val, rt_val,
                                             rs_hit, rs_fwd, rt_hit, rt_fwd));
    idle_gap(no_gaps ? 0 : gap_length());
  endtask

  task automatic wait_until_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] expv, logic [31:0] actv);
    if (expv !== actv) begin
      $error("%s: expected %h, got %h", name, expv, actv);
      fail_count++;
    end
  endtask

  // Result checker: every strobed result against the oldest pending decode
  always @(posedge clk) begin
    if (out_valid === 1'b1) begin
      if (pending_decodes.size() == 0) begin
        $error("result transaction with no decode pending");
        fail_count++;
      end else begin
        head_decode = pending_decodes.pop_front();
        check_field("alu_function", 32'(head_decode.alu_function),
                    32'(out_alu_function));
        check_field("alu_b_immediate", 32'(head_decode.alu_b_immediate),
                    32'(out_alu_b_immediate));
        check_field("immediate", head_decode.immediate, out_immediate);
        check_field("dest_reg", 32'(head_decode.dest_reg), 32'(out_dest_reg));
        check_field("mem_access", 32'(head_decode.mem_access), 32'(out_mem_access));
        check_field("mem_bytes", 32'(head_decode.mem_bytes), 32'(out_mem_bytes));
        check_field("branch_eval", 32'(head_decode.branch_eval), 32'(out_branch_eval));
        check_field("branch_taken", 32'(head_decode.branch_taken),
                    32'(out_branch_taken));
        check_field("branch_target", head_decode.branch_target, out_branch_target);
        check_field("exception_code", 32'(head_decode.exception_code),
                    32'(out_exception_code));
        check_field("operand_a", head_decode.operand_a, out_operand_a);
        check_field("operand_b", head_decode.operand_b, out_operand_b);
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // R-format: ALU ops, nop, break, unknown funct, register zero
  task automatic test_register_ops();
    send_decode(r_word(5'd31, 5'd31, 5'd31, FN_ADDU), 32'h0, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 1'b1, 32'h0, 1'b1, 32'h0);
    send_decode(r_word(5'd1, 5'd2, 5'd3, FN_AND), 32'h0040_0000, 32'h0F0F_0F0F,
                32'h00FF_00FF, 1'b0, 32'h0, 1'b0, 32'h0);
    send_decode(r_word(5'd0, 5'd0, 5'd5, FN_OR), 32'h0040_0004, 32'hDEAD_BEEF,
                32'hCAFE_F00D, 1'b1, 32'h1, 1'b1, 32'h2);
    send_decode({OPC_RFMT, 5'd3, 5'd4, 5'd7, 5'd9, FN_NOP}, 32'h0040_0008,
                32'h1234_5678, 32'h8765_4321, 1'b0, 32'h0, 1'b0, 32'h0);
    send_decode({OPC_RFMT, 20'hABCDE, FN_BREAK}, 32'h0040_000C, 32'h0000_0001,
                32'h8000_0000, 1'b0, 32'h0, 1'b0, 32'h0);
    send_decode(r_word(5'd9, 5'd10, 5'd11, FN_TOP), 32'h0040_0010, 32'h5555_5555,
                32'hAAAA_AAAA, 1'b0, 32'h0, 1'b0, 32'h0);
    send_decode(r_word(5'd4, 5'd5, 5'd0, FN_ADDU), 32'h0040_0014, 32'h0,
                32'h0, 1'b0, 32'h0, 1'b0, 32'h0);
  endtask

  // I-format: extension, memory kinds, unknown opcodes
  task automatic test_immediate_ops();
    send_decode(i_word(OPC_ADDIU, 5'd1, 5'd2, 16'h8000), 32'h100, 32'h7FFF_FFFF,
                32'h0, 1'b0, 32'h0, 1'b0, 32'h0);
    send_decode(i_word(OPC_ADDIU, 5'd31, 5'd0, 16'h7FFF), 32'h104, 32'hFFFF_FFFF,
                32'h1111_1111, 1'b0, 32'h0, 1'b0, 32'h0);
    send_decode(i_word(OPC_ANDI, 5'd6, 5'd7, 16'hFFFF), 32'h108, 32'hF0F0_F0F0,
                32'h0, 1'b0, 32'h0, 1'b0, 32'h0);
    send_decode(i_word(OPC_ORI, 5'd8, 5'd9, 16'h8001), 32'h10C, 32'h0,
                32'h0, 1'b0, 32'h0, 1'b0, 32'h0);
    send_decode(i_word(OPC_LHU, 5'd29, 5'd30, 16'hFFFC), 32'h110, 32'h1000_0000,
                32'h0, 1'b0, 32'h0, 1'b0, 32'h0);
    send_decode(i_word(OPC_SH, 5'd29, 5'd30, 16'h0004), 32'h114, 32'h1000_0000,
                32'hBEEF_BEEF, 1'b0, 32'h0, 1'b0, 32'h0);
    send_decode(i_word(OPC_TOP, 5'd12, 5'd13, 16'h8000), 32'h118, 32'h3,
                32'h4, 1'b0, 32'h0, 1'b0, 32'h0);
    send_decode(i_word(OPC_REGIMM, 5'd14, 5'd15, 16'h0010), 32'h11C, 32'h5,
                32'h6, 1'b0, 32'h0, 1'b0, 32'h0);
  endtask

  // Jumps and branches: region wrap, target wrap, forwarding, register zero
  task automatic test_branch_ops();
    send_decode({OPC_J, 26'h3FF_FFFF}, 32'hFFFF_FFFC, 32'h0, 32'h0,
                1'b0, 32'h0, 1'b0, 32'h0);
    send_decode({OPC_J, 26'h000_0000}, 32'h7FFF_FFFC, 32'h0, 32'h0,
                1'b0, 32'h0, 1'b0, 32'h0);
    send_decode(i_word(OPC_BEQ, 5'd1, 5'd2, 16'h8000), 32'h0, 32'hA5A5_A5A5,
                32'hA5A5_A5A5, 1'b0, 32'h0, 1'b0, 32'h0);
    send_decode(i_word(OPC_BEQ, 5'd1, 5'd2, 16'h0001), 32'h200, 32'hA5A5_A5A5,
                32'hA5A5_A5A5, 1'b1, 32'h5A5A_5A5A, 1'b0, 32'h0);
    send_decode(i_word(OPC_BNE, 5'd0, 5'd0, 16'hFFFF), 32'h204, 32'h1,
                32'h2, 1'b1, 32'h3, 1'b1, 32'h4);
    send_decode(i_word(OPC_BNE, 5'd3, 5'd4, 16'h7FFF), 32'hFFFF_FFF0, 32'h9,
                32'h9, 1'b0, 32'h0, 1'b1, 32'h8);
    send_decode(i_word(OPC_BEQ, 5'd5, 5'd6, 16'h0002), 32'h208, 32'h1,
                32'h2, 1'b1, 32'h7, 1'b1, 32'h7);
  endtask

  // Mostly well-formed subset instructions with random content, some raw noise
  function automatic logic [31:0] random_instruction();
    logic [31:0] rnd;
    logic [31:0] word;
    logic [5:0]  fn;
    int          pick;
    rnd  = $urandom;
    pick = $urandom_range(0, 19);
    case ($urandom_range(0, 4))
      0:       fn = FN_ADDU;
      1:       fn = FN_AND;
      2:       fn = FN_OR;
      3:       fn = FN_NOP;
      default: fn = FN_BREAK;
    endcase
    case (pick)
      0, 1, 2: word = {OPC_RFMT, rnd[25:6], fn};
      3:       word = {OPC_RFMT, rnd[25:0]};
      4:       word = {OPC_J, rnd[25:0]};
      5, 6:    word = {OPC_BEQ, rnd[25:0]};
      7, 8:    word = {OPC_BNE, rnd[25:0]};
      9, 10:   word = {OPC_ADDIU, rnd[25:0]};
      11:      word = {OPC_ANDI, rnd[25:0]};
      12:      word = {OPC_ORI, rnd[25:0]};
      13:      word = {OPC_LHU, rnd[25:0]};
      14:      word = {OPC_SH, rnd[25:0]};
      default: word = $urandom;
    endcase
    // register zero on either source now and then
    if ($urandom_range(0, 5) == 0) word[25:21] = 5'd0;
    if ($urandom_range(0, 5) == 0) word[20:16] = 5'd0;
    return word;
  endfunction

  task automatic test_random_stream(int count);
    logic [31:0] common;
    logic [31:0] vals[4];
    for (int i = 0; i < count; i++) begin
      // alternate stretches of back-to-back traffic with gappy traffic
      if (i % 100 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      if (i % 350 == 349) wait_until_drained();
      case ($urandom_range(0, 7))
        0:       common = 32'h0;
        1:       common = 32'hFFFF_FFFF;
        default: common = $urandom;
      endcase
      // shared values make branch compares come out equal often enough
      foreach (vals[k]) vals[k] = $urandom_range(0, 1) ? common : $urandom;
      send_decode(random_instruction(), $urandom, vals[0], vals[1],
                  1'($urandom_range(0, 1)), vals[2], 1'($urandom_range(0, 1)), vals[3]);
    end
    no_gaps = 1'b0;
  endtask

  // Sequence
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_register_ops();
    test_immediate_ops();
    test_branch_ops();
    wait_until_drained();
    test_random_stream(RANDOM_ITEMS);
    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== mips_subset_decode_stage.f =====
hw/rtl/msd_pkg.sv
hw/rtl/mips_subset_decode_stage.sv
tb/sv/mips_subset_decode_stage_test.sv
